// File: sv/dfr_pkg.sv
package dfr_pkg;

  localparam int unsigned KeyWidth   = 48;
  localparam int unsigned BlockWidth = 64;
  localparam int unsigned KeySlots   = 16;
  localparam int unsigned SlotWidth  = 4;

  typedef enum logic {
    KIND_LOAD_KEY = 1'b0,
    KIND_BLOCK    = 1'b1
  } kind_e;

  typedef logic [3:0] sbox_row_t [64];

  localparam sbox_row_t SBOX [8] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12,
      4'd5, 4'd9, 4'd0, 4'd7, 4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8, 4'd4, 4'd1, 4'd14, 4'd8,
      4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14,
      4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13,
      4'd12, 4'd0, 4'd5, 4'd10, 4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5, 4'd0, 4'd14, 4'd7, 4'd11,
      4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12,
      4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7,
      4'd11, 4'd4, 4'd2, 4'd8, 4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1, 4'd13, 4'd6, 4'd4, 4'd9,
      4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3,
      4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5,
      4'd11, 4'd12, 4'd4, 4'd15, 4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9, 4'd10, 4'd6, 4'd9, 4'd0,
      4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11,
      4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15,
      4'd13, 4'd0, 4'd14, 4'd9, 4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd11,
      4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9,
      4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4,
      4'd14, 4'd7, 4'd5, 4'd11, 4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8, 4'd9, 4'd14, 4'd15, 4'd5,
      4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7,
      4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7,
      4'd5, 4'd10, 4'd6, 4'd1, 4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6, 4'd1, 4'd4, 4'd11, 4'd13,
      4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15,
      4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14,
      4'd5, 4'd0, 4'd12, 4'd7, 4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4, 4'd1,
      4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0,
      4'd3, 4'd5, 4'd6, 4'd11}
  };

  typedef logic [5:0] sel48_t [48];
  typedef logic [5:0] sel32_t [32];

  localparam sel48_t ESEL = '{
    6'd32, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
    6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam sel32_t PSEL = '{
    6'd16, 6'd7, 6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17, 6'd1, 6'd15, 6'd23, 6'd26,
    6'd5, 6'd18, 6'd31, 6'd10, 6'd2, 6'd8, 6'd24, 6'd14, 6'd32, 6'd27, 6'd3, 6'd9,
    6'd19, 6'd13, 6'd30, 6'd6, 6'd22, 6'd11, 6'd4, 6'd25
  };

  function automatic logic [47:0] expand_half(input logic [31:0] r);
    logic [47:0] e;
    e = '0;
    for (int i = 0; i < 48; i++) begin
      e[47-i] = r[5'(32 - int'(ESEL[i]))];
    end
    return e;
  endfunction

  function automatic logic [31:0] sbox_layer(input logic [47:0] x);
    logic [31:0] s;
    logic [5:0]  six;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      six = x[42-6*i +: 6];
      s[28-4*i +: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    return s;
  endfunction

  function automatic logic [31:0] p_layer(input logic [31:0] s);
    logic [31:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      p[31-i] = s[5'(32 - int'(PSEL[i]))];
    end
    return p;
  endfunction

endpackage

// File: sv/dfr_round_unit.sv
module dfr_round_unit
  import dfr_pkg::*;
(
  input  logic [63:0] blk_i,
  input  logic [47:0] key_i,
  output logic [63:0] blk_o
);

  logic [31:0] f;

  always_comb begin
    f = p_layer(sbox_layer(expand_half(blk_i[31:0]) ^ key_i));
    blk_o = {blk_i[31:0], blk_i[63:32] ^ f};
  end

endmodule

// File: sv/des_feistel_rounds_core.sv
// Channel  | Dir | tdata                                       | tuser
// s_axis   | in  | [3:0] key_slot, [51:4] key_word,            | kind
//          |     | [115:52] data_block, [119:116] zero         |
// m_axis   | out | [63:0] result_block                         | -
// One round per pipeline stage: ROUND_COUNT stages, one block per cycle while m_axis is not stalled.
// Results leave from the last stage register; key loads pass through as bubbles.
// Reset clears the stage valid bits; the key store is not reset.
// A stall at m_axis holds every stage and lowers s_axis_tready.
// A key load waits at s_axis until no block is in flight.
module des_feistel_rounds_core
  import dfr_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,   // key_slot, key_word, data_block
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata    // result_block
);

  logic [47:0] key_mem [KeySlots];
  logic [ROUND_COUNT-1:0] vld_q;
  logic [63:0] blk_q [ROUND_COUNT];
  logic [63:0] rnd_out [ROUND_COUNT];
  logic adv;
  logic in_acc;

  assign adv = m_axis_tready || !vld_q[ROUND_COUNT-1];
  assign s_axis_tready = adv && (s_axis_tuser == KIND_BLOCK || vld_q == '0);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == KIND_LOAD_KEY) begin
      key_mem[s_axis_tdata[3:0]] <= s_axis_tdata[51:4];
    end
  end

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_rnd
    if (r == 0) begin : g_first
      dfr_round_unit u_rnd (
        .blk_i(s_axis_tdata[115:52]), .key_i(key_mem[r]), .blk_o(rnd_out[r]));
    end else begin : g_next
      dfr_round_unit u_rnd (
        .blk_i(blk_q[r-1]), .key_i(key_mem[r]), .blk_o(rnd_out[r]));
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        blk_q[r] <= rnd_out[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q[0] <= in_acc && s_axis_tuser == KIND_BLOCK;
      for (int i = 1; i < ROUND_COUNT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign m_axis_tvalid = vld_q[ROUND_COUNT-1];
  assign m_axis_tdata  = blk_q[ROUND_COUNT-1];

endmodule

// File: sv/dfr_checker.sv
module dfr_checker
  import dfr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tuser == KIND_BLOCK |-> s_axis_tready)
    else $error("block request blocked with empty output");

  a_load_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tuser == KIND_LOAD_KEY && m_axis_tvalid |-> !s_axis_tready)
    else $error("key load taken while a block was in flight");

endmodule

bind des_feistel_rounds_core dfr_checker u_dfr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata));
